// ===== sv/reliable_datagram_frame_parser_core_defines.svh =====
// Assertion macros for the frame parser RTL, included by rdfp_queue.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef RELIABLE_DATAGRAM_FRAME_PARSER_CORE_DEFINES_SVH
`define RELIABLE_DATAGRAM_FRAME_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RDFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdfp assertion failed");
`define RDFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdfp assertion failed");
`else
`define RDFP_ASSERT_SAME(label, ante, cons)
`define RDFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/rdfp_pkg.sv =====
// Types, codes and constants of the frame parser.
// No dependencies; imported by the parser front end, result queue and top level.
package rdfp_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Flags byte layout and length conversion
    localparam int REL_MSB     = 7;
    localparam int REL_LSB     = 5;
    localparam int FRAG_BIT    = 4;
    localparam int LEN_SHIFT   = 3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RELIABLE   = 2'd0,
        CFG_SEQUENCED  = 2'd1,
        CFG_ORDERED    = 2'd2,
        CFG_ORDER_ONLY = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_LAST    = 2'd2
    } kind_t;

    typedef enum logic [9:0] {
        PH_FLAGS   = 10'b00_0000_0001,
        PH_LEN     = 10'b00_0000_0010,
        PH_REL     = 10'b00_0000_0100,
        PH_SEQ     = 10'b00_0000_1000,
        PH_ORD     = 10'b00_0001_0000,
        PH_CHAN    = 10'b00_0010_0000,
        PH_CSIZE   = 10'b00_0100_0000,
        PH_CID     = 10'b00_1000_0000,
        PH_FIDX    = 10'b01_0000_0000,
        PH_PAYLOAD = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]  reliability;
        logic        fragmented;
        logic [12:0] payload_length;
        logic [23:0] reliable_index;
        logic [23:0] sequenced_index;
        logic [23:0] ordered_index;
        logic [7:0]  order_lane;
        logic [31:0] bundle_size;
        logic [15:0] bundle_id;
        logic [31:0] fragment_index;
    } hdr_t;

    typedef struct packed {
        kind_t      kind;
        hdr_t       hdr;
        logic [7:0] payload_byte;
    } rec_t;

endpackage

// ===== sv/rdfp_front.sv =====
// Front end: per-byte phase machine, header field capture and class masks.
// Depends on rdfp_pkg; pushes finished result records into rdfp_queue.
module rdfp_front
    import rdfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            data_byte,
    input  logic                  restart,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  push,
    output rec_t                  rec
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  fcnt_reg, fcnt_next;
    hdr_t        hdr_reg, hdr_next;
    logic [12:0] remain_reg, remain_next;
    logic [7:0]  rel_mask_reg, seq_mask_reg, ord_mask_reg;

    logic        start;
    logic        last_byte;
    phase_t      nxt;

    function automatic logic [2:0] field_len(input phase_t ph);
        case (ph)
            PH_LEN, PH_CID:                 field_len = 3'd2;
            PH_REL, PH_SEQ, PH_ORD:         field_len = 3'd3;
            PH_CSIZE, PH_FIDX:              field_len = 3'd4;
            default:                        field_len = 3'd1;
        endcase
    endfunction

    // PH_FLAGS as the answer means no header field is left
    function automatic phase_t next_field(input phase_t ph, input logic rel, input logic seq,
                                          input logic ord, input logic frag);
        phase_t tail;
        tail = frag ? PH_CSIZE : PH_FLAGS;
        case (ph)
            PH_LEN:   next_field = rel ? PH_REL : seq ? PH_SEQ : ord ? PH_ORD : tail;
            PH_REL:   next_field = seq ? PH_SEQ : ord ? PH_ORD : tail;
            PH_SEQ:   next_field = ord ? PH_ORD : tail;
            PH_ORD:   next_field = PH_CHAN;
            PH_CHAN:  next_field = tail;
            PH_CSIZE: next_field = frag ? PH_CID : PH_FLAGS;
            PH_CID:   next_field = frag ? PH_FIDX : PH_FLAGS;
            default:  next_field = PH_FLAGS;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rel_mask_reg <= 8'd220;
            seq_mask_reg <= 8'd18;
            ord_mask_reg <= 8'd154;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_RELIABLE:  rel_mask_reg <= cfg_data;
                CFG_SEQUENCED: seq_mask_reg <= cfg_data;
                CFG_ORDERED:   ord_mask_reg <= cfg_data;
                default:       ; // ordered-only set has no parse effect
            endcase
        end
    end

    assign start = restart ||
        !(phase_reg inside {PH_LEN, PH_REL, PH_SEQ, PH_ORD, PH_CHAN,
                            PH_CSIZE, PH_CID, PH_FIDX, PH_PAYLOAD});
    assign last_byte = (fcnt_reg + 3'd1) == field_len(phase_reg);
    assign nxt = next_field(phase_reg,
                            rel_mask_reg[hdr_reg.reliability],
                            seq_mask_reg[hdr_reg.reliability],
                            ord_mask_reg[hdr_reg.reliability],
                            hdr_reg.fragmented);

    always_comb
    begin
        phase_next       = phase_reg;
        fcnt_next        = fcnt_reg;
        hdr_next         = hdr_reg;
        remain_next      = remain_reg;
        push             = 1'b0;
        rec.kind         = KIND_HEADER;
        rec.hdr          = hdr_reg;
        rec.payload_byte = 8'd0;

        if (take)
        begin
            if (start)
            begin
                // Flags byte: drop anything held and start a new header
                hdr_next             = '0;
                hdr_next.reliability = data_byte[REL_MSB:REL_LSB];
                hdr_next.fragmented  = data_byte[FRAG_BIT];
                remain_next          = 13'd0;
                fcnt_next            = 3'd0;
                phase_next           = PH_LEN;
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                push             = 1'b1;
                rec.payload_byte = data_byte;
                if (remain_reg <= 13'd1)
                begin
                    rec.kind    = KIND_LAST;
                    remain_next = 13'd0;
                    phase_next  = PH_FLAGS;
                end
                else
                begin
                    rec.kind    = KIND_PAYLOAD;
                    remain_next = remain_reg - 13'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        // Bit length to bytes: high byte lands at bit 5
                        if (fcnt_reg == 3'd0)
                            hdr_next.payload_length = {data_byte, 5'd0};
                        else
                            hdr_next.payload_length = hdr_reg.payload_length |
                                13'(data_byte >> LEN_SHIFT);
                    end
                    PH_REL:
                        hdr_next.reliable_index = {hdr_reg.reliable_index[15:0], data_byte};
                    PH_SEQ:
                        hdr_next.sequenced_index = {hdr_reg.sequenced_index[15:0], data_byte};
                    PH_ORD:
                        hdr_next.ordered_index = {hdr_reg.ordered_index[15:0], data_byte};
                    PH_CHAN:
                        hdr_next.order_lane = data_byte;
                    PH_CSIZE:
                        hdr_next.bundle_size = {hdr_reg.bundle_size[23:0], data_byte};
                    PH_CID:
                        hdr_next.bundle_id = {hdr_reg.bundle_id[7:0], data_byte};
                    default:
                        hdr_next.fragment_index = {hdr_reg.fragment_index[23:0], data_byte};
                endcase

                if (!last_byte)
                    fcnt_next = fcnt_reg + 3'd1;
                else
                begin
                    fcnt_next = 3'd0;
                    if (nxt != PH_FLAGS)
                        phase_next = nxt;
                    else
                    begin
                        // Header complete: emit the record, then stream the payload if its length is not zero
                        push        = 1'b1;
                        rec.hdr     = hdr_next;
                        remain_next = hdr_next.payload_length;
                        phase_next  = (hdr_next.payload_length != 13'd0) ? PH_PAYLOAD
                                                                         : PH_FLAGS;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FLAGS;
            fcnt_reg   <= 3'd0;
            hdr_reg    <= '0;
            remain_reg <= 13'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fcnt_reg   <= fcnt_next;
            hdr_reg    <= hdr_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== sv/rdfp_queue.sv =====
// Back end: short queue of result records that drives the output channel.
// Depends on rdfp_pkg and the assertion macros header.
`include "reliable_datagram_frame_parser_core_defines.svh"
module rdfp_queue
    import rdfp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t wr_rec,
    output logic not_full,
    output logic head_valid,
    input  logic head_ready,
    output rec_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign not_full   = count_reg != CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RDFP_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `RDFP_ASSERT_SAME(a_no_push_full, push, count_reg != CW'(DEPTH))
    `RDFP_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `RDFP_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== sv/reliable_datagram_frame_parser_core.sv =====
// out_valid rises right after the edge that accepts a byte that finishes a result record.
// Throughput: one byte per cycle; in_ready drops only while the queue holds
// QDEPTH results that the output side has not taken.
// Reset (rst_n, asynchronous): masks to 220/18/154, parser expects a flags
// byte, queue empty. No clearing pass.
module reliable_datagram_frame_parser_core
    import rdfp_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [2:0]            reliability,
    output logic                  fragmented,
    output logic [12:0]           payload_length,
    output logic [23:0]           reliable_index,
    output logic [23:0]           sequenced_index,
    output logic [23:0]           ordered_index,
    output logic [7:0]            order_lane,
    output logic [31:0]           bundle_size,
    output logic [15:0]           bundle_id,
    output logic [31:0]           fragment_index,
    output logic [7:0]            payload_byte,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic take;
    logic push;
    rec_t wr_rec;
    rec_t head;

    assign take = in_valid && in_ready;

    rdfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .restart   (restart),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .rec       (wr_rec)
    );

    rdfp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_rec     (wr_rec),
        .not_full   (in_ready),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign kind            = head.kind;
    assign reliability     = head.hdr.reliability;
    assign fragmented      = head.hdr.fragmented;
    assign payload_length  = head.hdr.payload_length;
    assign reliable_index  = head.hdr.reliable_index;
    assign sequenced_index = head.hdr.sequenced_index;
    assign ordered_index   = head.hdr.ordered_index;
    assign order_lane      = head.hdr.order_lane;
    assign bundle_size     = head.hdr.bundle_size;
    assign bundle_id       = head.hdr.bundle_id;
    assign fragment_index  = head.hdr.fragment_index;
    assign payload_byte    = head.payload_byte;

endmodule
